@@ design/bhpq_pkg.sv @@
// Shared types and constants for the binary heap priority queue.
// Holds the request operation codes, the sequencer state type and the register map.
// No dependencies.
package bhpq_pkg;

    localparam int VALUE_W  = 32;
    localparam int OP_W     = 2;
    localparam int PADDR_W  = 3;
    localparam int PDATA_W  = 32;

    localparam logic REG_HEAP_ORDER = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_PEEK   = 2'd3
    } op_t;

    typedef enum logic [9:0] {
        ST_IDLE    = 10'b0000000001,
        ST_UP_RD   = 10'b0000000010,
        ST_UP_CMP  = 10'b0000000100,
        ST_DN_LAST = 10'b0000001000,
        ST_DN_LOAD = 10'b0000010000,
        ST_DN_RD1  = 10'b0000100000,
        ST_DN_RD2  = 10'b0001000000,
        ST_DN_PICK = 10'b0010000000,
        ST_DN_CMP  = 10'b0100000000,
        ST_FIN     = 10'b1000000000
    } state_t;

endpackage

@@ design/bhpq_ram.sv @@
// Generic single-clock RAM with one write port and one registered read port.
// Holds the heap entries. No dependencies.
module bhpq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ design/bhpq_cmp.sv @@
// Shared order compare unit of the heap sequencer.
// Tells whether key a must sit below key b under the selected heap order. No dependencies.
module bhpq_cmp #(
    parameter int KEY_WIDTH = 32
) (
    input  logic [KEY_WIDTH-1:0] key_a,
    input  logic [KEY_WIDTH-1:0] key_b,
    input  logic                 min_root,
    output logic                 a_loses
);

    logic a_lt_b;
    logic a_gt_b;

    assign a_lt_b  = $signed(key_a) < $signed(key_b);
    assign a_gt_b  = $signed(key_a) > $signed(key_b);
    assign a_loses = min_root ? a_gt_b : a_lt_b;

endmodule

@@ design/binary_heap_priority_queue.sv @@
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tuser: operation; tdata: value
// m_axis    out  tvalid/tready          tdata: root_value, entry_count, is_empty, overflow
// apb       in   psel/penable/pready    heap_order at byte address 0
//
// The heap RAM needs no clearing. An insert starts the key at the end of the heap and
// lifts it level by level until it reaches the root or stops below its parent. A
// delete-root moves the last entry to the root and sinks it level by level, reading a
// single child at a single-child node; deleting the only entry skips the sinking. Clear,
// peek, a dropped insert and an empty delete end at once. A result waiting on m_axis holds
// the next request in its final state, and the input is not ready until that result leaves.
// Top level of the binary heap priority queue. Depends on bhpq_pkg, bhpq_ram and bhpq_cmp.
module binary_heap_priority_queue
    import bhpq_pkg::*;
#(
    parameter int CAPACITY  = 1024,
    parameter int KEY_WIDTH = 32,
    parameter int CW        = $clog2(CAPACITY + 1),
    parameter int MW        = ((VALUE_W + CW + 2 + 7) / 8) * 8
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [VALUE_W-1:0] s_axis_tdata,  // [31:0] value
    input  logic [OP_W-1:0]    s_axis_tuser,  // [1:0] operation
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // root_value [31:0], entry_count, is_empty, overflow, zero fill
    output logic [MW-1:0]      m_axis_tdata,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    localparam int AW = $clog2(CAPACITY);
    localparam int IW = AW + 2;
    localparam int KW = KEY_WIDTH;

    state_t            state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [AW-1:0]     pos_reg, pos_next;
    logic [AW-1:0]     pick_reg, pick_next;
    logic [KW-1:0]     key_reg, key_next;
    logic [KW-1:0]     child_reg, child_next;
    logic [KW-1:0]     root_reg, root_next;
    logic              ovf_reg, ovf_next;
    logic              order_reg;
    logic              m_valid_reg, m_valid_next;
    logic [MW-1:0]     m_data_reg, m_data_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [KW-1:0]     ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [KW-1:0]     ram_rdata;
    logic [KW-1:0]     cmp_a;
    logic [KW-1:0]     cmp_b;
    logic              cmp_lose;

    logic [KW-1:0]     in_key;
    logic [VALUE_W-1:0] root_ext;
    logic [AW-1:0]     pos_m1;
    logic [AW-1:0]     parent_idx;
    logic [IW-1:0]     first_idx;
    logic [IW-1:0]     second_idx;
    logic [IW-1:0]     n_ext;
    logic              out_free;
    logic              in_take;
    op_t               op;

    for (genvar i = 0; i < KW; i++) begin : g_in_key
        if (i < VALUE_W) begin : g_bit
            assign in_key[i] = s_axis_tdata[i];
        end else begin : g_zero
            assign in_key[i] = 1'b0;
        end
    end

    for (genvar i = 0; i < VALUE_W; i++) begin : g_root_ext
        if (i < KW) begin : g_bit
            assign root_ext[i] = root_reg[i];
        end else begin : g_sign
            assign root_ext[i] = root_reg[KW-1];
        end
    end

    bhpq_ram #(
        .WIDTH (KW),
        .DEPTH (CAPACITY)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bhpq_cmp #(
        .KEY_WIDTH (KW)
    ) u_cmp (
        .key_a    (cmp_a),
        .key_b    (cmp_b),
        .min_root (order_reg),
        .a_loses  (cmp_lose)
    );

    assign pos_m1     = pos_reg - AW'(1);
    assign parent_idx = AW'(pos_m1 >> 1);
    assign first_idx  = IW'({pos_reg, 1'b1});
    assign second_idx = first_idx + IW'(1);
    assign n_ext      = IW'(count_reg);
    assign out_free   = !m_valid_reg || m_axis_tready;
    assign in_take    = s_axis_tvalid && (state_reg == ST_IDLE);
    assign op         = op_t'(s_axis_tuser);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        pos_next     = pos_reg;
        pick_next    = pick_reg;
        key_next     = key_reg;
        child_next   = child_reg;
        ovf_next     = ovf_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = pos_reg;
        ram_wdata    = key_reg;
        ram_raddr    = pos_reg;
        cmp_a        = ram_rdata;
        cmp_b        = key_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_take) begin
                    ovf_next = 1'b0;
                    unique case (op)
                        OP_INSERT: begin
                            if (count_reg == CW'(CAPACITY)) begin
                                ovf_next   = 1'b1;
                                state_next = ST_FIN;
                            end else begin
                                pos_next   = count_reg[AW-1:0];
                                key_next   = in_key;
                                count_next = count_reg + CW'(1);
                                state_next = ST_UP_RD;
                            end
                        end
                        OP_DELETE: begin
                            if (count_reg == '0) begin
                                state_next = ST_FIN;
                            end else begin
                                count_next = count_reg - CW'(1);
                                state_next = ST_DN_LAST;
                            end
                        end
                        OP_CLEAR: begin
                            count_next = '0;
                            state_next = ST_FIN;
                        end
                        OP_PEEK: begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_UP_RD: begin
                if (pos_reg == '0) begin
                    ram_we     = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    ram_raddr  = parent_idx;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                ram_we = 1'b1;
                if (cmp_lose) begin
                    ram_wdata  = ram_rdata;
                    pos_next   = parent_idx;
                    state_next = ST_UP_RD;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_DN_LAST: begin
                ram_raddr  = count_reg[AW-1:0];
                state_next = ST_DN_LOAD;
            end
            ST_DN_LOAD: begin
                key_next   = ram_rdata;
                pos_next   = '0;
                state_next = (count_reg == '0) ? ST_FIN : ST_DN_RD1;
            end
            ST_DN_RD1: begin
                if (first_idx >= n_ext) begin
                    ram_we     = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    ram_raddr  = first_idx[AW-1:0];
                    state_next = ST_DN_RD2;
                end
            end
            ST_DN_RD2: begin
                child_next = ram_rdata;
                pick_next  = first_idx[AW-1:0];
                if (second_idx < n_ext) begin
                    ram_raddr  = second_idx[AW-1:0];
                    state_next = ST_DN_PICK;
                end else begin
                    state_next = ST_DN_CMP;
                end
            end
            ST_DN_PICK: begin
                cmp_a = ram_rdata;
                cmp_b = child_reg;
                if (!cmp_lose) begin
                    child_next = ram_rdata;
                    pick_next  = second_idx[AW-1:0];
                end
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                cmp_a  = key_reg;
                cmp_b  = child_reg;
                ram_we = 1'b1;
                if (cmp_lose) begin
                    ram_wdata  = child_reg;
                    pos_next   = pick_reg;
                    state_next = ST_DN_RD1;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = MW'({ovf_reg, (count_reg == '0), count_reg,
                                        (count_reg == '0) ? VALUE_W'(0) : root_ext});
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        root_next = root_reg;
        if (ram_we && ram_waddr == '0) begin
            root_next = ram_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            ovf_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
            order_reg   <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            ovf_reg     <= ovf_next;
            m_valid_reg <= m_valid_next;
            if (psel && penable && pwrite && paddr[PADDR_W-1] == REG_HEAP_ORDER) begin
                order_reg <= pwdata[0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg    <= pos_next;
        pick_reg   <= pick_next;
        key_reg    <= key_next;
        child_reg  <= child_next;
        root_reg   <= root_next;
        m_data_reg <= m_data_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign pready        = 1'b1;
    assign prdata        = (paddr[PADDR_W-1] == REG_HEAP_ORDER) ?
                           PDATA_W'(order_reg) : '0;

endmodule

@@ design/bhpq_checker.sv @@
// Port-level checker for the binary heap priority queue, bound to the top level.
// Depends on bhpq_pkg and binary_heap_priority_queue.
module bhpq_checker
    import bhpq_pkg::*;
#(
    parameter int CAPACITY = 1024,
    parameter int CW       = $clog2(CAPACITY + 1),
    parameter int MW       = ((VALUE_W + CW + 2 + 7) / 8) * 8
) (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic [VALUE_W-1:0] s_axis_tdata,
    input logic [OP_W-1:0]    s_axis_tuser,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [MW-1:0]      m_axis_tdata,
    input logic               psel,
    input logic               penable,
    input logic               pwrite,
    input logic [PADDR_W-1:0] paddr,
    input logic [PDATA_W-1:0] pwdata,
    input logic [PDATA_W-1:0] prdata,
    input logic               pready
);

    logic [VALUE_W-1:0] out_root;
    logic [CW-1:0]      out_count;
    logic               out_empty;
    logic               out_ovf;
    logic               order_write;

    assign out_root    = m_axis_tdata[VALUE_W-1:0];
    assign out_count   = m_axis_tdata[VALUE_W+CW-1:VALUE_W];
    assign out_empty   = m_axis_tdata[VALUE_W+CW];
    assign out_ovf     = m_axis_tdata[VALUE_W+CW+1];
    assign order_write = psel && penable && pwrite && pready &&
                         paddr[PADDR_W-1] == REG_HEAP_ORDER;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("request taken without a busy cycle");

    a_empty_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> (out_empty == (out_count == '0)) &&
                          (!out_empty || out_root == '0))
        else $error("empty flag, count and root disagree");

    a_ovf_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && out_ovf |-> out_count == CW'(CAPACITY))
        else $error("overflow reported below capacity");

    a_order_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        order_write ##1 (psel && !pwrite && paddr[PADDR_W-1] == REG_HEAP_ORDER)
        |-> prdata[0] == $past(pwdata[0]))
        else $error("heap order register reads back wrong");

endmodule

bind binary_heap_priority_queue bhpq_checker #(.CAPACITY(CAPACITY)) u_bhpq_checker (.*);
